@@ rtl/jdc_pkg.sv @@
// Shared types, constants and lookup functions for the day number to date converter.
`default_nettype none
package jdc_pkg;

	localparam int unsigned JDC_LATENCY = 12;

	localparam logic [14:0] JD_OFFSET   = 15'd32044;
	localparam logic [17:0] DAYS_400Y   = 18'd146097;
	localparam logic [14:0] RECIP_400Y  = 15'd29398;
	localparam logic [10:0] DAYS_4Y     = 11'd1461;
	localparam logic [13:0] RECIP_4Y    = 14'd11483;
	localparam logic [7:0]  MONTH_SPAN  = 8'd153;
	localparam logic [8:0]  RECIP_SPAN  = 9'd428;
	localparam logic [6:0]  DAYS_100Y   = 7'd100;
	localparam logic [12:0] YEAR_BIAS   = 13'd4800;
	localparam logic [2:0]  DAYS_WEEK   = 3'd7;

	localparam logic [3:0] MON_FEB = 4'd2;
	localparam logic [3:0] MON_APR = 4'd4;
	localparam logic [3:0] MON_JUN = 4'd6;
	localparam logic [3:0] MON_SEP = 4'd9;
	localparam logic [3:0] MON_NOV = 4'd11;

	typedef struct packed {
		logic       zero;
		logic [5:0] wsum;
	} side_t;

	typedef struct packed {
		logic        vld;
		side_t       side;
		logic [7:0]  cent;
		logic [17:0] n2;
	} cent_t;

	typedef struct packed {
		logic       vld;
		side_t      side;
		logic [7:0] cent;
		logic [6:0] q;
		logic [8:0] e;
		logic [3:0] m;
	} yday_t;

	typedef struct packed {
		logic        vld;
		logic        date_valid;
		logic [15:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [2:0]  weekday;
		logic        leap;
		logic [4:0]  mlen;
	} res_t;

	function automatic logic [8:0] month_start(input logic [3:0] m);
		logic [8:0] r;
		unique case (m)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] month_len(input logic leap, input logic [3:0] month);
		logic [4:0] r;
		unique case (month) inside
			MON_APR, MON_JUN, MON_SEP, MON_NOV: r = 5'd30;
			MON_FEB:                            r = 5'd28 + 5'(leap);
			default:                            r = 5'd31;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

@@ rtl/jdc_cent_div.sv @@
// Offset, century division and remainder stages (pipeline stages 1 to 4).
`default_nettype none
module jdc_cent_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [22:0]     day_number,
	output jdc_pkg::cent_t  cent_o
);
	import jdc_pkg::*;

	logic        vld_s1, vld_s2, vld_s3, vld_s4;
	side_t       side_s1, side_s2, side_s3, side_s4;
	logic [25:0] n1_s1, n1_s2;
	logic [7:0]  est_s2, est_s3;
	logic [18:0] rem_s3;
	logic [7:0]  cent_s4;
	logic [17:0] n2_s4;

	logic [23:0] jdn_ext;
	logic [23:0] a_c;
	logic [5:0]  dsum_c;
	logic [40:0] prod1_c;
	logic [25:0] prod2_c;
	logic [25:0] rem_c;
	logic        ge_c;
	logic [18:0] rem_fix_c;

	assign jdn_ext = {1'b0, day_number};
	assign a_c     = jdn_ext + 24'(JD_OFFSET);

	always_comb begin
		dsum_c = 6'd1;
		for (int i = 0; i < 8; i++) begin
			dsum_c = dsum_c + 6'(jdn_ext[3*i +: 3]);
		end
	end

	assign prod1_c   = 41'(n1_s1) * 41'(RECIP_400Y);
	assign prod2_c   = 26'(est_s2) * 26'(DAYS_400Y);
	assign rem_c     = n1_s2 - prod2_c;
	assign ge_c      = rem_s3 >= 19'(DAYS_400Y);
	assign rem_fix_c = ge_c ? rem_s3 - 19'(DAYS_400Y) : rem_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		side_s1 <= '{zero: (day_number == 23'd0), wsum: dsum_c};
		n1_s1   <= {a_c, 2'b11};

		side_s2 <= side_s1;
		n1_s2   <= n1_s1;
		est_s2  <= prod1_c[39:32];

		side_s3 <= side_s2;
		est_s3  <= est_s2;
		rem_s3  <= rem_c[18:0];

		side_s4 <= side_s3;
		cent_s4 <= est_s3 + 8'(ge_c);
		n2_s4   <= rem_fix_c[17:0] | 18'd3;
	end

	assign cent_o = '{vld: vld_s4, side: side_s4, cent: cent_s4, n2: n2_s4};

endmodule
`default_nettype wire

@@ rtl/jdc_yday_div.sv @@
// Year-in-century and month divisions (pipeline stages 5 to 10).
`default_nettype none
module jdc_yday_div (
	input  logic           clk,
	input  logic           arst_n,
	input  jdc_pkg::cent_t cent_i,
	output jdc_pkg::yday_t yday_o
);
	import jdc_pkg::*;

	logic        vld_s5, vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;
	side_t       side_s5, side_s6, side_s7, side_s8, side_s9, side_s10;
	logic [7:0]  cent_s5, cent_s6, cent_s7, cent_s8, cent_s9, cent_s10;
	logic [17:0] n2_s5;
	logic [6:0]  est2_s5, est2_s6;
	logic [11:0] rem2_s6;
	logic [6:0]  q_s7, q_s8, q_s9, q_s10;
	logic [8:0]  e_s7, e_s8, e_s9, e_s10;
	logic [10:0] n3_s7, n3_s8;
	logic [3:0]  est3_s8, est3_s9;
	logic [8:0]  rem3_s9;
	logic [3:0]  m_s10;

	logic [31:0] prod2_c;
	logic [17:0] back2_c;
	logic [17:0] rem2_c;
	logic        ge2_c;
	logic [11:0] rem2_fix_c;
	logic [8:0]  e_c;
	logic [19:0] prod3_c;
	logic [10:0] back3_c;
	logic [10:0] rem3_c;

	assign prod2_c    = 32'(cent_i.n2) * 32'(RECIP_4Y);
	assign back2_c    = 18'(est2_s5) * 18'(DAYS_4Y);
	assign rem2_c     = n2_s5 - back2_c;
	assign ge2_c      = rem2_s6 >= 12'(DAYS_4Y);
	assign rem2_fix_c = ge2_c ? rem2_s6 - 12'(DAYS_4Y) : rem2_s6;
	assign e_c        = rem2_fix_c[10:2];
	assign prod3_c    = 20'(n3_s7) * 20'(RECIP_SPAN);
	assign back3_c    = 11'(est3_s8) * 11'(MONTH_SPAN);
	assign rem3_c     = n3_s8 - back3_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else begin
			vld_s5  <= cent_i.vld;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		side_s5  <= cent_i.side;
		cent_s5  <= cent_i.cent;
		n2_s5    <= cent_i.n2;
		est2_s5  <= prod2_c[30:24];

		side_s6  <= side_s5;
		cent_s6  <= cent_s5;
		est2_s6  <= est2_s5;
		rem2_s6  <= rem2_c[11:0];

		side_s7  <= side_s6;
		cent_s7  <= cent_s6;
		q_s7     <= est2_s6 + 7'(ge2_c);
		e_s7     <= e_c;
		n3_s7    <= 11'({e_c, 2'b00}) + 11'(e_c) + 11'd2;

		side_s8  <= side_s7;
		cent_s8  <= cent_s7;
		q_s8     <= q_s7;
		e_s8     <= e_s7;
		n3_s8    <= n3_s7;
		est3_s8  <= prod3_c[19:16];

		side_s9  <= side_s8;
		cent_s9  <= cent_s8;
		q_s9     <= q_s8;
		e_s9     <= e_s8;
		est3_s9  <= est3_s8;
		rem3_s9  <= rem3_c[8:0];

		side_s10 <= side_s9;
		cent_s10 <= cent_s9;
		q_s10    <= q_s9;
		e_s10    <= e_s9;
		m_s10    <= est3_s9 + 4'(rem3_s9 >= 9'(MONTH_SPAN));
	end

	assign yday_o = '{vld: vld_s10, side: side_s10, cent: cent_s10, q: q_s10,
		e: e_s10, m: m_s10};

endmodule
`default_nettype wire

@@ rtl/jdc_fields.sv @@
// Date field assembly, leap test, weekday and month length (pipeline stages 11 and 12).
`default_nettype none
module jdc_fields (
	input  logic           clk,
	input  logic           arst_n,
	input  jdc_pkg::yday_t yday_i,
	output jdc_pkg::res_t  res_o
);
	import jdc_pkg::*;

	logic        vld_s11, vld_s12;
	side_t       side_s11;
	logic [3:0]  month_s11;
	logic [4:0]  day_s11;
	logic [14:0] yb_s11;
	logic        leap_s11;
	res_t        res_s12;

	logic        wrap_c;
	logic [3:0]  month_c;
	logic [8:0]  day_c;
	logic [6:0]  y2_c;
	logic        hund_c;
	logic        y2_is_100_c;
	logic [1:0]  cent_lo_c;
	logic        leap_c;

	logic [15:0] year_c;
	logic [3:0]  f1_c;
	logic [3:0]  f2_c;
	logic [2:0]  wd_c;

	assign wrap_c      = yday_i.m >= 4'd10;
	assign month_c     = wrap_c ? yday_i.m - 4'd9 : yday_i.m + 4'd3;
	assign day_c       = yday_i.e - month_start(yday_i.m) + 9'd1;
	assign y2_c        = yday_i.q + 7'(wrap_c);
	assign y2_is_100_c = y2_c == DAYS_100Y;
	assign hund_c      = (y2_c == 7'd0) || y2_is_100_c;
	assign cent_lo_c   = yday_i.cent[1:0] + 2'(y2_is_100_c);
	assign leap_c      = (y2_c[1:0] == 2'd0) && (!hund_c || (cent_lo_c == 2'd0));

	assign year_c = {1'b0, yb_s11} - 16'(YEAR_BIAS);
	assign f1_c   = 4'(side_s11.wsum[5:3]) + 4'(side_s11.wsum[2:0]);
	assign f2_c   = 4'(f1_c[3]) + 4'(f1_c[2:0]);
	assign wd_c   = (f2_c >= 4'(DAYS_WEEK)) ? 3'(f2_c - 4'(DAYS_WEEK)) : f2_c[2:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
		end else begin
			vld_s11 <= yday_i.vld;
			vld_s12 <= vld_s11;
		end
	end

	always_ff @(posedge clk) begin
		side_s11  <= yday_i.side;
		month_s11 <= month_c;
		day_s11   <= day_c[4:0];
		yb_s11    <= 15'(yday_i.cent) * 15'(DAYS_100Y) + 15'(y2_c);
		leap_s11  <= leap_c;

		if (side_s11.zero) begin
			res_s12 <= '0;
		end else begin
			res_s12 <= '{vld: 1'b0, date_valid: 1'b1, year: year_c, month: month_s11,
				day: day_s11, weekday: wd_c, leap: leap_s11,
				mlen: month_len(leap_s11, month_s11)};
		end
	end

	always_comb begin
		res_o     = res_s12;
		res_o.vld = vld_s12;
	end

endmodule
`default_nettype wire

@@ rtl/julian_day_to_calendar_date_unit.sv @@
// Top level of the Julian day number to Gregorian date converter.
//
// Usage:
//   Drive day_number and raise start for one cycle per item. busy is always
//   low, so an item is taken at every rising edge where start is high; a new
//   item may follow in every cycle.
//   Each item returns one result after it passes all pipeline stages, with
//   done high for a single cycle. The result ports carry date_valid,
//   year_out, month_out, day_of_month, weekday_out, leap_flag and
//   month_length, and are meaningful only while done is high.
//   Throughput is one item per cycle. The stages come from three constant
//   divisions (centuries, years in the century, month of the year), each done
//   as a reciprocal multiply, a back multiply and a remainder correction in
//   separate stages, plus one stage that adds the day offset and two stages
//   that assemble the fields.
//   A day number of zero returns date_valid low and all other fields zero.
//   Reset clears the valid bits of all stages; items in flight are dropped.
//   The receiver cannot stall: a result is shown once and never held.
`default_nettype none
module julian_day_to_calendar_date_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [22:0]        day_number,
	output logic               done,
	output logic               date_valid,
	output logic signed [15:0] year_out,
	output logic [3:0]         month_out,
	output logic [4:0]         day_of_month,
	output logic [2:0]         weekday_out,
	output logic               leap_flag,
	output logic [4:0]         month_length
);
	import jdc_pkg::*;

	cent_t cent_w;
	yday_t yday_w;
	res_t  res_w;

	assign busy = 1'b0;

	jdc_cent_div u_cent_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.day_number (day_number),
		.cent_o     (cent_w)
	);

	jdc_yday_div u_yday_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cent_i (cent_w),
		.yday_o (yday_w)
	);

	jdc_fields u_fields (
		.clk    (clk),
		.arst_n (arst_n),
		.yday_i (yday_w),
		.res_o  (res_w)
	);

	assign done         = res_w.vld;
	assign date_valid   = res_w.date_valid;
	assign year_out     = res_w.year;
	assign month_out    = res_w.month;
	assign day_of_month = res_w.day;
	assign weekday_out  = res_w.weekday;
	assign leap_flag    = res_w.leap;
	assign month_length = res_w.mlen;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##JDC_LATENCY done)
		else $error("item taken without a result after the pipeline latency");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		!start |-> ##JDC_LATENCY !done)
		else $error("result strobe without a matching item");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && date_valid |-> month_out >= 4'd1 && month_out <= 4'd12 &&
			day_of_month >= 5'd1 && day_of_month <= month_length)
		else $error("month or day out of range");

	a_zero_item: assert property (@(posedge clk) disable iff (!arst_n)
		done && !date_valid |-> year_out == 16'sd0 && month_out == 4'd0 &&
			day_of_month == 5'd0 && weekday_out == 3'd0 && !leap_flag &&
			month_length == 5'd0)
		else $error("invalid item with nonzero fields");

	a_feb_len: assert property (@(posedge clk) disable iff (!arst_n)
		done && date_valid && month_out == MON_FEB |->
			month_length == 5'd28 + 5'(leap_flag))
		else $error("february length disagrees with leap flag");

endmodule
`default_nettype wire
